[design/ppc_pkg.sv]
// ppc_pkg: shared types, register codes, reset values and helper functions
// for the plot pixel classifier; no dependencies

package ppc_pkg;

    // default plot size, handed to the top level parameters
    localparam int DEF_PLOT_WIDTH  = 640;
    localparam int DEF_PLOT_HEIGHT = 480;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 40;

    // register indexes on the config port
    localparam logic [CFG_ADDR_W-1:0] CFG_PIXEL_STEP    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_X      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_Y      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS_SQ     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_CELL_SIZE     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_GRID_OFFSET_X = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_GRID_OFFSET_Y = 3'd6;

    // register reset values
    localparam logic        [31:0] RST_PIXEL_STEP    = 32'd6554;
    localparam logic signed [39:0] RST_ORIGIN_X      = -40'sd2097152;
    localparam logic signed [39:0] RST_ORIGIN_Y      = -40'sd1572864;
    localparam logic        [39:0] RST_RADIUS_SQ     = 40'd589824;
    localparam logic        [7:0]  RST_CELL_SIZE     = 8'd100;
    localparam logic signed [9:0]  RST_GRID_OFFSET_X = -10'sd80;
    localparam logic signed [9:0]  RST_GRID_OFFSET_Y = -10'sd40;

    // pixel classes
    localparam logic [1:0] CLS_BACKGROUND = 2'd0;
    localparam logic [1:0] CLS_MAJOR      = 2'd1;
    localparam logic [1:0] CLS_MINOR      = 2'd2;
    localparam logic [1:0] CLS_CURVE      = 2'd3;

    localparam logic [3:0] MASK_NONE = 4'd0;
    localparam logic [3:0] MASK_ALL  = 4'd15;

    // grid remainder width: |pos + offset| stays below 2048
    localparam int REM_W = 11;

    typedef struct packed {
        logic [9:0] column;
        logic [8:0] row;
    } t_pix_in;

    typedef struct packed {
        logic [1:0] pixel_class;
        logic [3:0] corner_mask;
    } t_pix_out;

    // one restoring step of the grid remainder
    function automatic logic [REM_W-1:0] rem_step(logic [REM_W-1:0] r, logic [7:0] cs,
                                                 int sh);
        logic [REM_W+7:0] d;
        d = (REM_W+8)'(cs) << sh;
        if ({8'b0, r} >= d) begin
            return r - d[REM_W-1:0];
        end
        return r;
    endfunction

    // magnitude clipped to 28 bits, top bit flags magnitude of 2^28 or more
    function automatic logic [28:0] mag_clip(logic signed [43:0] v);
        logic [43:0] m;
        m = v[43] ? 44'(-v) : 44'(v);
        return {|m[43:28], m[27:0]};
    endfunction

    // grid line class from a floor remainder d in 0..cs-1
    function automatic logic [1:0] line_kind(logic [7:0] d, logic [7:0] cs);
        logic [9:0] three_cs;
        logic [7:0] q3;
        three_cs = 10'(cs) + {1'b0, cs, 1'b0};
        q3       = three_cs[9:2];
        if (cs == 8'd0) begin
            return CLS_BACKGROUND;
        end
        if (d == (cs >> 2) || d == (cs >> 1) || d == q3) begin
            return CLS_MINOR;
        end
        if (d == 8'd0) begin
            return CLS_MAJOR;
        end
        return CLS_BACKGROUND;
    endfunction

endpackage

[design/plot_pixel_classifier.sv]
// plot_pixel_classifier: pixel class and circle corner mask, five stage pipeline
// depends on ppc_pkg

// One pixel beat is accepted every clock as long as the downstream side keeps
// taking results. The pipeline runs: stage 1 forms column*step and row*step
// (10x32 and 9x32 multipliers) and starts the grid offset sums, stage 2 adds
// the origin to get the four corner coordinates, stage 3 takes magnitudes,
// stage 4 squares them (four 28x28 multipliers), stage 5 compares against
// radius_sq and picks the class. Alongside, the grid position modulo cell_size
// is worked out by a restoring remainder spread over stages 2 to 4, four steps
// in each of stages 2 and 3 and the last three in stage 4. Each stage holds its
// beat only while the stage after it is full and held, so bubbles close up
// under stall and o_stall falls as soon as i_stall does. Pixels outside the
// plot give background with an empty mask. Registers must be written only
// while the pipeline is empty; the block itself does not enforce this.

module plot_pixel_classifier #(
    parameter int PLOT_WIDTH  = ppc_pkg::DEF_PLOT_WIDTH,
    parameter int PLOT_HEIGHT = ppc_pkg::DEF_PLOT_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  ppc_pkg::t_pix_in                  i_pix,
    output logic                              o_valid,
    input  logic                              i_stall,
    output ppc_pkg::t_pix_out                 o_pix,
    input  logic                              i_cfg_we,
    input  logic [ppc_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [ppc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import ppc_pkg::*;

    // configuration registers
    logic        [31:0] r_pixel_step;
    logic signed [39:0] r_origin_x;
    logic signed [39:0] r_origin_y;
    logic        [39:0] r_radius_sq;
    logic        [7:0]  r_cell_size;
    logic signed [9:0]  r_grid_offset_x;
    logic signed [9:0]  r_grid_offset_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_step    <= RST_PIXEL_STEP;
            r_origin_x      <= RST_ORIGIN_X;
            r_origin_y      <= RST_ORIGIN_Y;
            r_radius_sq     <= RST_RADIUS_SQ;
            r_cell_size     <= RST_CELL_SIZE;
            r_grid_offset_x <= RST_GRID_OFFSET_X;
            r_grid_offset_y <= RST_GRID_OFFSET_Y;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_PIXEL_STEP:    r_pixel_step    <= i_cfg_wdata[31:0];
                CFG_ORIGIN_X:      r_origin_x      <= i_cfg_wdata[39:0];
                CFG_ORIGIN_Y:      r_origin_y      <= i_cfg_wdata[39:0];
                CFG_RADIUS_SQ:     r_radius_sq     <= i_cfg_wdata[39:0];
                CFG_CELL_SIZE:     r_cell_size     <= i_cfg_wdata[7:0];
                CFG_GRID_OFFSET_X: r_grid_offset_x <= i_cfg_wdata[9:0];
                CFG_GRID_OFFSET_Y: r_grid_offset_y <= i_cfg_wdata[9:0];
                default: begin
                end
            endcase
        end
    end

    // stage enables: a stage loads when it is empty or the next one loads
    logic r_vld1, r_vld2, r_vld3, r_vld4, r_vld5;
    logic en1, en2, en3, en4, en5;

    assign en5     = !r_vld5 || !i_stall;
    assign en4     = !r_vld4 || en5;
    assign en3     = !r_vld3 || en4;
    assign en2     = !r_vld2 || en3;
    assign en1     = !r_vld1 || en2;
    assign o_stall = !en1;

    // ---------------- stage 1: products, oob flag, grid sums
    logic        [41:0]      r_px1;
    logic        [40:0]      r_py1;
    logic                    r_oob1;
    logic        [REM_W-1:0] r_gc1, r_gr1;
    logic                    r_nc1, r_nr1;

    logic signed [11:0] sum_c, sum_r;
    logic               oob_in;

    assign sum_c  = $signed({2'b0, i_pix.column}) + 12'(r_grid_offset_x);
    assign sum_r  = $signed({3'b0, i_pix.row}) + 12'(r_grid_offset_y);
    assign oob_in = (32'(i_pix.column) >= PLOT_WIDTH) || (32'(i_pix.row) >= PLOT_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else if (en1) begin
            r_vld1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_px1  <= 42'(i_pix.column) * 42'(r_pixel_step);
            r_py1  <= 41'(i_pix.row) * 41'(r_pixel_step);
            r_oob1 <= oob_in;
            r_nc1  <= sum_c[11];
            r_nr1  <= sum_r[11];
            r_gc1  <= sum_c[11] ? REM_W'(-sum_c) : REM_W'(sum_c);
            r_gr1  <= sum_r[11] ? REM_W'(-sum_r) : REM_W'(sum_r);
        end
    end

    // ---------------- stage 2: corner coordinates, remainder steps 10..7
    logic signed [43:0]      r_x0, r_x1, r_y0, r_y1;
    logic                    r_oob2;
    logic        [REM_W-1:0] r_gc2, r_gr2;
    logic                    r_nc2, r_nr2;

    logic signed [43:0] px_s, py_s, ox_s, oy_s, st_s, ty;

    assign px_s = $signed({2'b0, r_px1});
    assign py_s = $signed({3'b0, r_py1});
    assign ox_s = {{4{r_origin_x[39]}}, r_origin_x};
    assign oy_s = {{4{r_origin_y[39]}}, r_origin_y};
    assign st_s = $signed({12'b0, r_pixel_step});
    assign ty   = py_s + oy_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else if (en2) begin
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_x0   <= px_s + ox_s;
            r_x1   <= px_s + ox_s + st_s;
            r_y0   <= -ty;
            r_y1   <= -ty - st_s;
            r_oob2 <= r_oob1;
            r_nc2  <= r_nc1;
            r_nr2  <= r_nr1;
            r_gc2  <= rem_step(rem_step(rem_step(rem_step(r_gc1, r_cell_size, 10),
                      r_cell_size, 9), r_cell_size, 8), r_cell_size, 7);
            r_gr2  <= rem_step(rem_step(rem_step(rem_step(r_gr1, r_cell_size, 10),
                      r_cell_size, 9), r_cell_size, 8), r_cell_size, 7);
        end
    end

    // ---------------- stage 3: magnitudes, remainder steps 6..3
    logic [28:0]      r_mx0, r_mx1, r_my0, r_my1;
    logic             r_oob3;
    logic [REM_W-1:0] r_gc3, r_gr3;
    logic             r_nc3, r_nr3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
        end else if (en3) begin
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_mx0  <= mag_clip(r_x0);
            r_mx1  <= mag_clip(r_x1);
            r_my0  <= mag_clip(r_y0);
            r_my1  <= mag_clip(r_y1);
            r_oob3 <= r_oob2;
            r_nc3  <= r_nc2;
            r_nr3  <= r_nr2;
            r_gc3  <= rem_step(rem_step(rem_step(rem_step(r_gc2, r_cell_size, 6),
                      r_cell_size, 5), r_cell_size, 4), r_cell_size, 3);
            r_gr3  <= rem_step(rem_step(rem_step(rem_step(r_gr2, r_cell_size, 6),
                      r_cell_size, 5), r_cell_size, 4), r_cell_size, 3);
        end
    end

    // ---------------- stage 4: squares, last remainder steps and floor fix
    logic [55:0] r_sx0, r_sx1, r_sy0, r_sy1;
    logic        r_bx0, r_bx1, r_by0, r_by1;
    logic        r_oob4;
    logic [7:0]  r_dc4, r_dr4;

    logic [REM_W-1:0] rem_c, rem_r;

    assign rem_c = rem_step(rem_step(rem_step(r_gc3, r_cell_size, 2), r_cell_size, 1),
                            r_cell_size, 0);
    assign rem_r = rem_step(rem_step(rem_step(r_gr3, r_cell_size, 2), r_cell_size, 1),
                            r_cell_size, 0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
        end else if (en4) begin
            r_vld4 <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_sx0  <= 56'(r_mx0[27:0]) * 56'(r_mx0[27:0]);
            r_sx1  <= 56'(r_mx1[27:0]) * 56'(r_mx1[27:0]);
            r_sy0  <= 56'(r_my0[27:0]) * 56'(r_my0[27:0]);
            r_sy1  <= 56'(r_my1[27:0]) * 56'(r_my1[27:0]);
            r_bx0  <= r_mx0[28];
            r_bx1  <= r_mx1[28];
            r_by0  <= r_my0[28];
            r_by1  <= r_my1[28];
            r_oob4 <= r_oob3;
            // truncating remainder turned into floor remainder for negative sums
            r_dc4  <= (r_nc3 && rem_c != '0) ? r_cell_size - rem_c[7:0] : rem_c[7:0];
            r_dr4  <= (r_nr3 && rem_r != '0) ? r_cell_size - rem_r[7:0] : rem_r[7:0];
        end
    end

    // ---------------- stage 5: circle test, class select, output register
    logic [56:0] lim;
    logic [3:0]  mask;
    logic [1:0]  kind_r, kind_c, cls;
    t_pix_out    r_out;

    assign lim = {1'b0, r_radius_sq, 16'b0};

    // corner order: (x0,y0) (x1,y0) (x1,y1) (x0,y1)
    assign mask[0] = !r_bx0 && !r_by0 && (57'(r_sx0) + 57'(r_sy0) <= lim);
    assign mask[1] = !r_bx1 && !r_by0 && (57'(r_sx1) + 57'(r_sy0) <= lim);
    assign mask[2] = !r_bx1 && !r_by1 && (57'(r_sx1) + 57'(r_sy1) <= lim);
    assign mask[3] = !r_bx0 && !r_by1 && (57'(r_sx0) + 57'(r_sy1) <= lim);

    assign kind_r = line_kind(r_dr4, r_cell_size);
    assign kind_c = line_kind(r_dc4, r_cell_size);

    always_comb begin
        if (mask != MASK_NONE && mask != MASK_ALL) begin
            cls = CLS_CURVE;
        end else if (kind_r != CLS_BACKGROUND) begin
            // horizontal line wins over vertical
            cls = kind_r;
        end else begin
            cls = kind_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld5 <= 1'b0;
        end else if (en5) begin
            r_vld5 <= r_vld4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            if (r_oob4) begin
                r_out.pixel_class <= CLS_BACKGROUND;
                r_out.corner_mask <= MASK_NONE;
            end else begin
                r_out.pixel_class <= cls;
                r_out.corner_mask <= mask;
            end
        end
    end

    assign o_valid = r_vld5;
    assign o_pix   = r_out;

endmodule

[design/ppc_checker.sv]
// ppc_checker: port level checks for plot_pixel_classifier, bound to the top
// depends on ppc_pkg and plot_pixel_classifier

module ppc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_stall,
    input ppc_pkg::t_pix_in               i_pix,
    input logic                           o_valid,
    input logic                           i_stall,
    input ppc_pkg::t_pix_out              o_pix,
    input logic                           i_cfg_we,
    input logic [ppc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input logic [ppc_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import ppc_pkg::*;

    // a held result beat stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pix))
        else $error("result beat changed under stall");

    // pipeline empties on reset
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result beat valid right after reset");

    // free output side never throttles the input
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output is free");

    // curve class exactly when the mask is mixed
    a_curve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_pix.pixel_class == CLS_CURVE) ==
                     (o_pix.corner_mask != MASK_NONE && o_pix.corner_mask != MASK_ALL)))
        else $error("pixel class disagrees with corner mask");

endmodule

bind plot_pixel_classifier ppc_checker u_ppc_checker (.*);

[verif/tb_top.sv]
// tb_top: self-checking testbench for plot_pixel_classifier, pixel beats in,
// class and corner mask beats out, checked against an in-bench predictor
// depends on ppc_pkg and design/plot_pixel_classifier.sv

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ppc_pkg::*;

    localparam int PLOT_W        = DEF_PLOT_WIDTH;
    localparam int PLOT_H        = DEF_PLOT_HEIGHT;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 10;
    // the config port decodes three address bits, index 7 holds no register
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 3'd7;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    t_pix_in               i_pix   = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    t_pix_out              o_pix;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // shadow copy of the register file, updated on every write
    logic        [31:0] step_r  = RST_PIXEL_STEP;
    logic signed [39:0] org_x_r = RST_ORIGIN_X;
    logic signed [39:0] org_y_r = RST_ORIGIN_Y;
    logic        [39:0] rad_r   = RST_RADIUS_SQ;
    logic        [7:0]  cell_r  = RST_CELL_SIZE;
    logic        [9:0]  offx_r  = RST_GRID_OFFSET_X;
    logic        [9:0]  offy_r  = RST_GRID_OFFSET_Y;

    // predicted result beats, oldest first
    t_pix_out pixel_results_due[$];
    t_pix_out head_pix;

    int error_count = 0;
    int cycle_count = 0;
    int gap_pct     = 0;
    int stall_pct   = 0;
    int hold_left   = 0;
    bit hold_req    = 1'b0;

    // where the circle sits on screen, used to aim pixels at the curve
    int view_cx = 320;
    int view_cy = 240;
    int view_r  = 30;

    always #5 i_clk = ~i_clk;

    plot_pixel_classifier dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pix       (i_pix),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pix       (o_pix),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // a*a + b*b <= radius_sq << 16, any magnitude of 2^28 or more is outside
    function automatic bit within_circle(longint a, longint b);
        longint unsigned ma;
        longint unsigned mb;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        if (ma >= (64'd1 << 28) || mb >= (64'd1 << 28)) begin
            return 1'b0;
        end
        return (ma * ma + mb * mb) <= ({24'd0, rad_r} << 16);
    endfunction

    // floor remainder of pos + offset against the cell size
    function automatic logic [1:0] grid_class(int pos, logic [9:0] off);
        int cs;
        int d;
        cs = cell_r;
        if (cs == 0) begin
            return CLS_BACKGROUND;
        end
        d = (pos + int'($signed(off))) % cs;
        if (d < 0) begin
            d += cs;
        end
        for (int n = 1; n < 4; n++) begin
            if (d == (n * cs) / 4) begin
                return CLS_MINOR;
            end
        end
        return (d == 0) ? CLS_MAJOR : CLS_BACKGROUND;
    endfunction

    function automatic t_pix_out classify_pixel(logic [9:0] col, logic [8:0] row);
        t_pix_out res;
        longint   s;
        longint   x0;
        longint   x1;
        longint   y0;
        longint   y1;
        logic [3:0] mask;
        res = '0;
        // off-plot pixels give background with an empty mask
        if (col >= PLOT_W || row >= PLOT_H) begin
            return res;
        end
        s  = longint'(step_r);
        x0 = longint'(col) * s + longint'(org_x_r);
        x1 = x0 + s;
        y0 = -(longint'(row) * s + longint'(org_y_r));
        y1 = y0 - s;
        mask[0] = within_circle(x0, y0);
        mask[1] = within_circle(x1, y0);
        mask[2] = within_circle(x1, y1);
        mask[3] = within_circle(x0, y1);
        res.corner_mask = mask;
        if (mask != MASK_NONE && mask != MASK_ALL) begin
            res.pixel_class = CLS_CURVE;
        end else begin
            // row line wins over column line
            res.pixel_class = grid_class(row, offy_r);
            if (res.pixel_class == CLS_BACKGROUND) begin
                res.pixel_class = grid_class(col, offx_r);
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------

    // one config write, shadow copy follows at once since the pipe is empty
    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_PIXEL_STEP:    step_r  = data[31:0];
            CFG_ORIGIN_X:      org_x_r = data[39:0];
            CFG_ORIGIN_Y:      org_y_r = data[39:0];
            CFG_RADIUS_SQ:     rad_r   = data[39:0];
            CFG_CELL_SIZE:     cell_r  = data[7:0];
            CFG_GRID_OFFSET_X: offx_r  = data[9:0];
            CFG_GRID_OFFSET_Y: offy_r  = data[9:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // drop valid, wait for every predicted beat, then let the pipe run dry
    task automatic settle_pipeline();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pixel_results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // offer one pixel beat, with random idle cycles ahead of it
    task automatic send_pixel(logic [9:0] col, logic [8:0] row);
        @(negedge i_clk);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_pix.column <= col;
        i_pix.row    <= row;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        pixel_results_due.push_back(classify_pixel(col, row));
    endtask

    // all seven registers; upper data bits beyond each register are junk on purpose
    task automatic program_regs(longint st, longint ox, longint oy, longint rq,
                                int cs, int gx, int gy);
        settle_pipeline();
        write_reg(CFG_PIXEL_STEP,    {8'($urandom), 32'(st)});
        write_reg(CFG_ORIGIN_X,      40'(ox));
        write_reg(CFG_ORIGIN_Y,      40'(oy));
        write_reg(CFG_RADIUS_SQ,     40'(rq));
        write_reg(CFG_CELL_SIZE,     {32'($urandom), 8'(cs)});
        write_reg(CFG_GRID_OFFSET_X, {30'($urandom), 10'(gx)});
        write_reg(CFG_GRID_OFFSET_Y, {30'($urandom), 10'(gy)});
    endtask

    // random view that puts a circle of view_r pixels somewhere on screen
    task automatic program_view();
        longint st;
        longint rr;
        int     cs;
        int     gx;
        int     gy;
        st      = $urandom_range(2000, 30000);
        view_cx = $urandom_range(0, PLOT_W - 1);
        view_cy = $urandom_range(0, PLOT_H - 1);
        view_r  = $urandom_range(3, 250);
        rr      = longint'(view_r) * st;
        case ($urandom_range(9))
            0:       cs = $urandom_range(0, 4);
            1:       cs = $urandom_range(201, 255);
            default: cs = $urandom_range(50, 200);
        endcase
        gx = ($urandom_range(9) == 0) ? int'($urandom_range(0, 1023)) - 512
                                      : int'($urandom_range(0, 799)) - 400;
        gy = ($urandom_range(9) == 0) ? int'($urandom_range(0, 1023)) - 512
                                      : int'($urandom_range(0, 799)) - 400;
        program_regs(st,
                     -(longint'(view_cx) * st) + longint'($urandom_range(0, st - 1)),
                     -(longint'(view_cy) * st) + longint'($urandom_range(0, st - 1)),
                     ((rr * rr) >> 16) + longint'($urandom_range(0, 255)),
                     cs, gx, gy);
    endtask

    // move pos onto a random quarter mark of the grid, kept inside 0..lim
    function automatic int snap_to_grid(int pos, logic [9:0] off, int lim);
        int cs;
        int d;
        int t;
        cs = cell_r;
        if (cs == 0) begin
            return pos;
        end
        d = (pos + int'($signed(off))) % cs;
        if (d < 0) begin
            d += cs;
        end
        t = pos - d + (int'($urandom_range(3)) * cs) / 4;
        while (t > lim) t -= cs;
        while (t < 0) t += cs;
        return (t > lim) ? pos : t;
    endfunction

    // mostly near the curve or on grid lines, some anywhere in the field range
    task automatic pick_pixel(output logic [9:0] col, output logic [8:0] row);
        int sel;
        int dx;
        int dy;
        int c;
        int r;
        sel = $urandom_range(99);
        if (sel < 45) begin
            dx = int'($urandom_range(0, 2 * view_r)) - view_r;
            dy = int'($sqrt(real'(view_r * view_r - dx * dx)));
            if ($urandom_range(1) == 1) begin
                dy = -dy;
            end
            c = view_cx + dx + int'($urandom_range(2)) - 1;
            r = view_cy + dy + int'($urandom_range(2)) - 1;
            if (c < 0 || c >= PLOT_W) c = $urandom_range(PLOT_W - 1);
            if (r < 0 || r >= PLOT_H) r = $urandom_range(PLOT_H - 1);
        end else if (sel < 70) begin
            c = snap_to_grid($urandom_range(PLOT_W - 1), offx_r, PLOT_W - 1);
            r = ($urandom_range(1) == 1) ? snap_to_grid($urandom_range(PLOT_H - 1), offy_r,
                                                        PLOT_H - 1)
                                         : int'($urandom_range(PLOT_H - 1));
        end else if (sel < 80) begin
            // whole field range, off-plot included
            c = $urandom_range(1023);
            r = $urandom_range(511);
        end else begin
            c = $urandom_range(PLOT_W - 1);
            r = $urandom_range(PLOT_H - 1);
        end
        col = 10'(c);
        row = 9'(r);
    endtask

    task automatic send_picked(int n);
        logic [9:0] col;
        logic [8:0] row;
        for (int i = 0; i < n; i++) begin
            pick_pixel(col, row);
            send_pixel(col, row);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset view: circle of radius three around column 320, row 240
    task automatic test_reset_view();
        send_pixel(0, 0);       send_pixel(639, 479);   // plot corners
        send_pixel(640, 0);     send_pixel(0, 480);     // just off the plot
        send_pixel(1023, 511);  send_pixel(1023, 0);    send_pixel(0, 511);
        send_pixel(320, 240);                           // circle center, all corners in
        send_pixel(350, 240);   send_pixel(290, 240);   // curve crossings
        send_pixel(320, 210);   send_pixel(320, 271);
        send_pixel(80, 140);                            // major column line
        send_pixel(105, 300);                           // minor column line
        send_pixel(80, 65);                             // row minor beats column major
        send_pixel(205, 40);                            // major row line
    endtask

    task automatic test_register_extremes();
        int grid_sizes[4] = '{0, 1, 50, 200};
        // zero step: corners coincide, never a curve
        view_cx = 320; view_cy = 240; view_r = 30;
        program_regs(0, -2097152, -1572864, 589824, 100, -80, -40);
        send_picked(8);
        // largest step, origins at both range ends, largest radius
        program_regs(64'hFFFF_FFFF, -(longint'(1) << 39), (longint'(1) << 39) - 1,
                     (longint'(1) << 40) - 1, 255, -512, 511);
        send_picked(8);
        // magnitude limit on the positive side
        program_regs(1, (longint'(1) << 28) - 2, 0, (longint'(1) << 40) - 1, 1, 0, 0);
        send_pixel(0, 0); send_pixel(1, 0); send_pixel(2, 0); send_pixel(1, 1);
        // and on the negative side with an empty radius
        program_regs(1, -(longint'(1) << 28), 0, 0, 2, 511, -512);
        send_pixel(0, 0); send_pixel(1, 0); send_pixel(0, 1);
        program_regs(1, -(longint'(1) << 28), 0, (longint'(1) << 40) - 1, 3, 0, 0);
        send_pixel(0, 0); send_pixel(1, 0); send_pixel(2, 2);
        // unit step, circle of radius three through exact corners
        view_cx = 0; view_cy = 0; view_r = 3;
        program_regs(65536, 0, 0, longint'(9) << 16, 4, 0, 0);
        send_pixel(3, 0); send_pixel(2, 0); send_pixel(0, 3); send_pixel(2, 2);
        send_pixel(0, 0);
        send_picked(6);
        // grid edge sizes with reset geometry
        view_cx = 320; view_cy = 240; view_r = 30;
        foreach (grid_sizes[i]) begin
            program_regs(6554, -2097152, -1572864, 589824, grid_sizes[i],
                         (i % 2 == 1) ? -400 : 399, (i % 2 == 1) ? 399 : -400);
            send_picked(8);
        end
        // unused index must change nothing
        settle_pipeline();
        write_reg(CFG_UNUSED, {$urandom, 8'($urandom)});
        send_picked(6);
    endtask

    task automatic run_random_views(int gap, int stall, int n_items);
        settle_pipeline();
        gap_pct   = gap;
        stall_pct = stall;
        for (int i = 0; i < n_items; i += 40) begin
            program_view();
            send_picked(40);
        end
    endtask

    task automatic test_streaming();
        run_random_views(0, 0, 280);
    endtask

    task automatic test_sender_gaps();
        run_random_views(46, 0, 280);
    endtask

    task automatic test_receiver_stalls();
        run_random_views(0, 46, 280);
    endtask

    task automatic test_mixed_idle();
        run_random_views(14, 14, 280);
    endtask

    // receiver holds off for a long stretch while pixels keep coming
    task automatic test_backpressure();
        settle_pipeline();
        gap_pct   = 0;
        stall_pct = 0;
        program_view();
        hold_req = 1'b1;
        send_picked(60);
    endtask

    // ------------------------------------------------------------------
    // receiver side: stall pattern and result check
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pixel_results_due.size() == 0) begin
                $error("result beat with nothing pending: pixel_class %0d corner_mask %0h",
                       o_pix.pixel_class, o_pix.corner_mask);
                error_count++;
            end else begin
                head_pix = pixel_results_due.pop_front();
                if (o_pix.pixel_class !== head_pix.pixel_class) begin
                    $error("pixel_class: expected %0d, got %0d",
                           head_pix.pixel_class, o_pix.pixel_class);
                    error_count++;
                end
                if (o_pix.corner_mask !== head_pix.corner_mask) begin
                    $error("corner_mask: expected %0h, got %0h",
                           head_pix.corner_mask, o_pix.corner_mask);
                    error_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_view();
        test_register_extremes();
        test_streaming();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idle();
        test_backpressure();
        settle_pipeline();
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
